// ===== hdl/puag_pkg.sv =====
// ----------------------------------------------------------------------------
// puag_pkg: shared types and constants of the polar unwarp address generator
// Widths, fixed-point formats, register codes and series constants.
// ----------------------------------------------------------------------------
package puag_pkg;

  localparam int PHASE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int ROWS_W     = 12;
  localparam int COLS_W     = 12;
  localparam int STEPS_W    = 13;
  localparam int ANGLE_W    = 13;
  localparam int RADIUS_W   = 11;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // q30 internal trig format
  localparam int Q_FRAC = 30;
  localparam int H_W    = Q_FRAC + 1;
  localparam logic [H_W-1:0] Q_ONE = H_W'(1) << Q_FRAC;
  localparam int TWO_PI_W = 33;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q30 = 33'd6746518852;

  localparam int TRIG_W   = TRIG_FRAC_BITS + 1;
  localparam int DIV_STAGES = ANGLE_W + PHASE_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;
  localparam int K_W       = 8;

  localparam logic [K_W-1:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [K_W-1:0] COS_DIV [COS_STEPS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // floor(2^32 / k), quotient off by at most one for a 30-bit dividend
  localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_ANGLE_STEPS = 2'd2
  } cfg_reg_t;

  // queue entry between phase divider and trig back end
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [RADIUS_W-1:0]   radius;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic                  valid;
    logic [ANGLE_W-1:0]    angle;
    logic [RADIUS_W-1:0]   radius;
    logic [STEPS_W-1:0]    rem;
    logic [PHASE_BITS-1:0] quot;
  } div_stage_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          quad;
    logic                upper;
    logic [RADIUS_W-1:0] radius;
    logic [Q_FRAC-1:0]   x;
    logic [Q_FRAC-1:0]   x2;
  } back_sb_t;

  // q30 magnitude to trig fraction, round half up, saturate
  function automatic logic [TRIG_FRAC_BITS-1:0] to_trig(input logic [H_W-1:0] v);
    logic [31:0] sum;
    logic [31:0] m;
    sum = 32'(v) + (32'd1 << (29 - TRIG_FRAC_BITS));
    m   = sum >> (30 - TRIG_FRAC_BITS);
    if (m > 32'((1 << TRIG_FRAC_BITS) - 1)) begin
      return {TRIG_FRAC_BITS{1'b1}};
    end
    return m[TRIG_FRAC_BITS-1:0];
  endfunction

endpackage

// ===== hdl/polar_unwarp_address_gen.sv =====
// ----------------------------------------------------------------------------
// polar_unwarp_address_gen: fisheye to panorama source address generator
// For each output pixel (angle, radius) returns the source pixel in the
// circular frame and whether it lies inside the frame.
// ----------------------------------------------------------------------------
// one item per clock sustained while the work queue has room and the output is
// taken; each item passes the phase division (one quotient bit per stage), the
// work queue, and then the trig series and coordinate math before its result;
// configuration writes are taken at any time, one per cycle, and must
// only happen while no item is in flight
module polar_unwarp_address_gen (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [puag_pkg::ANGLE_W-1:0]     in_angle_index,
  input  logic [puag_pkg::RADIUS_W-1:0]    in_radius_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [puag_pkg::COORD_W-1:0]     out_src_x,
  output logic [puag_pkg::COORD_W-1:0]     out_src_y,
  output logic                             out_in_bounds,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [puag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [puag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [puag_pkg::ROWS_W-1:0]  image_rows_r;
  logic [puag_pkg::COLS_W-1:0]  image_cols_r;
  logic [puag_pkg::STEPS_W-1:0] angle_steps_r;

  puag_pkg::fifo_stat_t q_stat;
  puag_pkg::work_t      q_wdata, q_rdata;
  logic                 q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r  <= puag_pkg::ROWS_W'(1440);
      image_cols_r  <= puag_pkg::COLS_W'(1440);
      angle_steps_r <= puag_pkg::STEPS_W'(3196);
    end else if (cfg_valid) begin
      case (cfg_index)
        puag_pkg::REG_IMAGE_ROWS:  image_rows_r  <= cfg_wdata[puag_pkg::ROWS_W-1:0];
        puag_pkg::REG_IMAGE_COLS:  image_cols_r  <= cfg_wdata[puag_pkg::COLS_W-1:0];
        puag_pkg::REG_ANGLE_STEPS: angle_steps_r <= cfg_wdata[puag_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  puag_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_angle_index  (in_angle_index),
    .in_radius_index (in_radius_index),
    .angle_steps     (angle_steps_r),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  puag_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  puag_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .image_rows    (image_rows_r),
    .image_cols    (image_cols_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_in_bounds (out_in_bounds)
  );

endmodule

// ===== hdl/puag_front.sv =====
// ----------------------------------------------------------------------------
// puag_front: phase divider
// Takes items and forms phase = floor(angle * 2^PHASE_BITS / steps), one
// quotient bit per stage, then pushes them into the work queue.
// ----------------------------------------------------------------------------
module puag_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [puag_pkg::ANGLE_W-1:0]    in_angle_index,
  input  logic [puag_pkg::RADIUS_W-1:0]   in_radius_index,
  input  logic [puag_pkg::STEPS_W-1:0]    angle_steps,
  input  puag_pkg::fifo_stat_t            q_stat,
  output logic                            q_push,
  output puag_pkg::work_t                 q_wdata
);

  localparam int N = puag_pkg::DIV_STAGES;

  puag_pkg::div_stage_t st_r [N];
  logic                 fe;
  logic [puag_pkg::STEPS_W-1:0] divisor;

  assign fe       = !q_stat.full;
  assign in_ready = fe;
  // zero steps acts as one
  assign divisor  = (angle_steps == '0) ? puag_pkg::STEPS_W'(1) : angle_steps;

  for (genvar i = 0; i < N; i++) begin : g_stage
    puag_pkg::div_stage_t         prev;
    logic                         dbit;
    logic [puag_pkg::STEPS_W:0]   trial;
    logic                         ge;
    puag_pkg::div_stage_t         st_nxt;

    always_comb begin
      if (i == 0) begin
        prev.valid  = in_valid;
        prev.angle  = in_angle_index;
        prev.radius = in_radius_index;
        prev.rem    = '0;
        prev.quot   = '0;
      end else begin
        prev = st_r[(i == 0) ? 0 : i-1];
      end
    end

    // dividend is angle followed by PHASE_BITS zero bits
    if (i < puag_pkg::ANGLE_W) begin : g_abit
      assign dbit = prev.angle[puag_pkg::ANGLE_W-1-i];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    always_comb begin
      trial  = {prev.rem, dbit};
      ge     = trial >= {1'b0, divisor};
      st_nxt = prev;
      st_nxt.rem  = ge ? puag_pkg::STEPS_W'(trial - {1'b0, divisor})
                       : puag_pkg::STEPS_W'(trial);
      st_nxt.quot = {prev.quot[puag_pkg::PHASE_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].valid <= 1'b0;
      end else if (fe) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  assign q_push         = fe && st_r[N-1].valid;
  assign q_wdata.phase  = st_r[N-1].quot;
  assign q_wdata.radius = st_r[N-1].radius;

endmodule

// ===== hdl/puag_fifo.sv =====
// ----------------------------------------------------------------------------
// puag_fifo: work queue
// Short queue between the phase divider and the trig back end.
// ----------------------------------------------------------------------------
module puag_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  puag_pkg::work_t      wdata,
  input  logic                 pop,
  output puag_pkg::work_t      rdata,
  output puag_pkg::fifo_stat_t stat
);

  puag_pkg::work_t                   mem_r [puag_pkg::FIFO_DEPTH];
  logic [puag_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [puag_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [puag_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign stat.full  = cnt_r == puag_pkg::FIFO_CNT_W'(puag_pkg::FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + puag_pkg::FIFO_CNT_W'(do_push) - puag_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/puag_back.sv =====
// ----------------------------------------------------------------------------
// puag_back: trig and coordinate pipeline
// Octant reduction, sin and cos series in q30, rounding to trig format,
// scaling by radius, centering and bounds check; last stage is the output.
// ----------------------------------------------------------------------------
module puag_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  puag_pkg::fifo_stat_t           q_stat,
  input  puag_pkg::work_t                q_rdata,
  output logic                           q_pop,
  input  logic [puag_pkg::ROWS_W-1:0]    image_rows,
  input  logic [puag_pkg::COLS_W-1:0]    image_cols,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [puag_pkg::COORD_W-1:0]   out_src_x,
  output logic [puag_pkg::COORD_W-1:0]   out_src_y,
  output logic                           out_in_bounds
);

  localparam int PB      = puag_pkg::PHASE_BITS;
  localparam int TFB     = puag_pkg::TRIG_FRAC_BITS;
  localparam int QF      = puag_pkg::Q_FRAC;
  localparam int HW      = puag_pkg::H_W;
  localparam int LAST    = 22;
  localparam int XP_W    = PB - 1 + puag_pkg::TWO_PI_W;
  localparam int PROD_W  = puag_pkg::TRIG_W + puag_pkg::RADIUS_W + 1;
  localparam int N_W     = PROD_W + 1;
  localparam int CX_W    = N_W - 1 - TFB;

  puag_pkg::back_sb_t sb_r [LAST+1];
  logic               be;

  assign be        = !sb_r[LAST].valid || out_ready;
  assign q_pop     = be && !q_stat.empty;
  assign out_valid = sb_r[LAST].valid;

  // stage 0: octant fold and angle in radians
  logic [PB-3:0]     rem_p;
  logic              upper_w;
  logic [PB-2:0]     xin;
  logic [XP_W-1:0]   xp_r;
  logic [QF-1:0]     x_w;
  logic [2*QF-1:0]   x2p_r;
  logic [QF-1:0]     x2_w;

  always_comb begin
    rem_p   = q_rdata.phase[PB-3:0];
    upper_w = rem_p[PB-3];
    xin     = upper_w ? (PB-1)'((PB-1)'(1) << (PB-2)) - (PB-1)'(rem_p) : (PB-1)'(rem_p);
  end

  assign x_w  = xp_r[PB+QF-1:PB];
  assign x2_w = x2p_r[2*QF-1:QF];

  puag_pkg::back_sb_t sb_nxt [LAST+1];

  always_comb begin
    sb_nxt[0]        = sb_r[0];
    sb_nxt[0].valid  = !q_stat.empty;
    sb_nxt[0].quad   = q_rdata.phase[PB-1:PB-2];
    sb_nxt[0].upper  = upper_w;
    sb_nxt[0].radius = q_rdata.radius;
    for (int i = 1; i <= LAST; i++) begin
      sb_nxt[i] = sb_r[i-1];
    end
    sb_nxt[1].x  = x_w;
    sb_nxt[2].x2 = x2_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) begin
        sb_r[i].valid <= 1'b0;
      end
    end else if (be) begin
      for (int i = 0; i <= LAST; i++) begin
        sb_r[i] <= sb_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      xp_r  <= XP_W'(xin) * XP_W'(puag_pkg::TWO_PI_Q30);
      x2p_r <= (2*QF)'(x_w) * (2*QF)'(x_w);
    end
  end

  // horner steps: h = 1 - floor(floor(x2*h)/k), three stages each
  logic [HW-1:0] ch_r [puag_pkg::COS_STEPS];
  logic [HW-1:0] sh_r [puag_pkg::SIN_STEPS];

  for (genvar j = 0; j < puag_pkg::COS_STEPS; j++) begin : g_cos
    logic [QF+HW-1:0]  p_r;
    logic [QF-1:0]     t_r;
    logic [QF+31:0]    m_r;
    logic [QF-1:0]     x2_in;
    logic [HW-1:0]     h_in;
    logic [QF-1:0]     t_w;
    logic [QF-1:0]     q0;
    logic [QF+7:0]     qk;
    logic [QF+7:0]     r;
    logic              ge;

    if (j == 0) begin : g_first
      assign x2_in = x2_w;
      assign h_in  = puag_pkg::Q_ONE;
    end else begin : g_next
      assign x2_in = sb_r[1+3*j].x2;
      assign h_in  = ch_r[(j == 0) ? 0 : j-1];
    end

    always_comb begin
      t_w = p_r[2*QF-1:QF];
      q0  = m_r[QF+31:32];
      qk  = (QF+8)'(q0) * (QF+8)'(puag_pkg::COS_DIV[j]);
      r   = (QF+8)'(t_r) - qk;
      ge  = r >= (QF+8)'(puag_pkg::COS_DIV[j]);
    end

    always_ff @(posedge clk) begin
      if (be) begin
        p_r     <= (QF+HW)'(x2_in) * (QF+HW)'(h_in);
        t_r     <= t_w;
        m_r     <= (QF+32)'(t_w) * (QF+32)'(puag_pkg::COS_RECIP[j]);
        ch_r[j] <= puag_pkg::Q_ONE - (HW'(q0) + HW'(ge));
      end
    end
  end

  for (genvar j = 0; j < puag_pkg::SIN_STEPS; j++) begin : g_sin
    logic [QF+HW-1:0]  p_r;
    logic [QF-1:0]     t_r;
    logic [QF+31:0]    m_r;
    logic [QF-1:0]     x2_in;
    logic [HW-1:0]     h_in;
    logic [QF-1:0]     t_w;
    logic [QF-1:0]     q0;
    logic [QF+7:0]     qk;
    logic [QF+7:0]     r;
    logic              ge;

    if (j == 0) begin : g_first
      assign x2_in = x2_w;
      assign h_in  = puag_pkg::Q_ONE;
    end else begin : g_next
      assign x2_in = sb_r[1+3*j].x2;
      assign h_in  = sh_r[(j == 0) ? 0 : j-1];
    end

    always_comb begin
      t_w = p_r[2*QF-1:QF];
      q0  = m_r[QF+31:32];
      qk  = (QF+8)'(q0) * (QF+8)'(puag_pkg::SIN_DIV[j]);
      r   = (QF+8)'(t_r) - qk;
      ge  = r >= (QF+8)'(puag_pkg::SIN_DIV[j]);
    end

    always_ff @(posedge clk) begin
      if (be) begin
        p_r     <= (QF+HW)'(x2_in) * (QF+HW)'(h_in);
        t_r     <= t_w;
        m_r     <= (QF+32)'(t_w) * (QF+32)'(puag_pkg::SIN_RECIP[j]);
        sh_r[j] <= puag_pkg::Q_ONE - (HW'(q0) + HW'(ge));
      end
    end
  end

  // sin = x * h, then align with cos
  logic [QF+HW-1:0] sp_r;
  logic [HW-1:0]    sv18_r, sv19_r;

  always_ff @(posedge clk) begin
    if (be) begin
      sp_r   <= (QF+HW)'(sb_r[16].x) * (QF+HW)'(sh_r[puag_pkg::SIN_STEPS-1]);
      sv18_r <= sp_r[QF+HW-1:QF];
      sv19_r <= sv18_r;
    end
  end

  // stage 20: quadrant mapping, rounding and sign
  logic [HW-1:0]                   s_base, c_base;
  logic [TFB-1:0]                  s_mag, c_mag;
  logic signed [puag_pkg::TRIG_W-1:0] s_pos, c_pos;
  logic signed [puag_pkg::TRIG_W-1:0] sin_nxt, cos_nxt;
  logic signed [puag_pkg::TRIG_W-1:0] sin_t_r, cos_t_r;

  always_comb begin
    s_base = sb_r[19].upper ? ch_r[puag_pkg::COS_STEPS-1] : sv19_r;
    c_base = sb_r[19].upper ? sv19_r : ch_r[puag_pkg::COS_STEPS-1];
    s_mag  = puag_pkg::to_trig(s_base);
    c_mag  = puag_pkg::to_trig(c_base);
    s_pos  = $signed({1'b0, s_mag});
    c_pos  = $signed({1'b0, c_mag});
    case (sb_r[19].quad)
      2'd0: begin
        sin_nxt = s_pos;
        cos_nxt = c_pos;
      end
      2'd1: begin
        sin_nxt = c_pos;
        cos_nxt = -s_pos;
      end
      2'd2: begin
        sin_nxt = -s_pos;
        cos_nxt = -c_pos;
      end
      default: begin
        sin_nxt = -c_pos;
        cos_nxt = s_pos;
      end
    endcase
  end

  // stage 21: scale by radius
  logic signed [PROD_W-1:0] xprod_r, yprod_r;

  always_ff @(posedge clk) begin
    if (be) begin
      sin_t_r <= sin_nxt;
      cos_t_r <= cos_nxt;
      xprod_r <= sin_t_r * $signed({1'b0, sb_r[20].radius});
      yprod_r <= cos_t_r * $signed({1'b0, sb_r[20].radius});
    end
  end

  // stage 22: center, truncate toward zero, bounds
  logic signed [N_W-1:0] nx, ny;
  logic [CX_W-1:0]       cx, cy;
  logic                  x_ok, y_ok, ib;

  always_comb begin
    nx = $signed({xprod_r[PROD_W-1], xprod_r})
       + $signed(N_W'({image_cols[puag_pkg::COLS_W-1:1], {TFB{1'b0}}}));
    ny = $signed({yprod_r[PROD_W-1], yprod_r})
       + $signed(N_W'({image_rows[puag_pkg::ROWS_W-1:1], {TFB{1'b0}}}));
    cx = nx[N_W-2:TFB];
    cy = ny[N_W-2:TFB];
    // a sum in (-1, 0) truncates to zero
    x_ok = nx[N_W-1] ? ((&nx[N_W-1:TFB]) && (|nx[TFB-1:0]) && (image_cols != '0))
                     : (cx < CX_W'(image_cols));
    y_ok = ny[N_W-1] ? ((&ny[N_W-1:TFB]) && (|ny[TFB-1:0]) && (image_rows != '0))
                     : (cy < CX_W'(image_rows));
    ib = x_ok && y_ok;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_in_bounds <= ib;
      out_src_x     <= (ib && !nx[N_W-1]) ? cx[puag_pkg::COORD_W-1:0] : '0;
      out_src_y     <= (ib && !ny[N_W-1]) ? cy[puag_pkg::COORD_W-1:0] : '0;
    end
  end

endmodule
